>>> rtl/cht_pkg.sv
// shared constants and types for the chained hash table
package cht_pkg;

	localparam int BUCKETS_DEF = 256;
	localparam int NODES_DEF   = 1024;

	localparam int MODE_W  = 2;
	localparam int KEY_W   = 31;
	localparam int VAL_W   = 32;
	localparam int NODE_IW = 10;
	localparam int CNT_W   = 9;

	localparam logic [CNT_W-1:0] BUCKET_COUNT_RST = 9'd256;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

	localparam int DIV_BITS  = 32;
	localparam int DIV_STEPS = 16;
	localparam int DIV_CW    = 4;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_HEAD_RD,
		ST_HEAD_CHK,
		ST_NODE_CHK,
		ST_OUT
	} state_t;

endpackage

>>> rtl/chained_hash_table_int_keys.sv
// chained hash table with integer keys over a fixed node pool
//
// Requests enter on the s_ channel: s_tuser carries the operation (insert,
// lookup, remove), s_tdata the key, the value and the node slot. Each request
// gives one result on the m_ channel: m_tuser is the found flag, m_tdata the
// looked-up value. The bucket count register is to be written on the
// cfg_ channel only while the block is idle; the block itself does not
// enforce it. One request at a time: a request passes through the remainder
// unit (two quotient bits per cycle), the bucket head read in ST_HEAD_RD and
// ST_HEAD_CHK, the chain walk in ST_NODE_CHK on lookup and remove, and the
// output register load in ST_OUT; the next request is taken after the result
// is loaded. The single read port of the node memories sets the walk rate.
// After reset the bucket head memory is swept, during which
// s_tready stays low; configuration writes are taken throughout.
// The result waits in the output register while m_tready is low; the next
// request is accepted and processed meanwhile and holds in its final state
// until the output register frees.
module chained_hash_table_int_keys #(
	parameter int BUCKETS = cht_pkg::BUCKETS_DEF,
	parameter int NODES   = cht_pkg::NODES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // key[30:0], value[62:31], node[72:63], zero
	input  logic [1:0]  s_tuser,  // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // result_value[31:0]
	output logic [0:0]  m_tuser,  // found[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data
);

	localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int NODE_W = $clog2(NODES);
	localparam int HEAD_W = NODE_W + 1;
	localparam int KV_W   = cht_pkg::KEY_W + cht_pkg::VAL_W;
	localparam logic [cht_pkg::CNT_W-1:0] DIV_MAX =
		(BUCKETS > 511) ? 9'd511 : 9'(BUCKETS);
	localparam logic [BKT_W-1:0] CLR_LAST = BKT_W'(BUCKETS - 1);

	cht_pkg::state_t state_q, state_d;

	logic [cht_pkg::CNT_W-1:0]  bucket_count_q;
	logic [cht_pkg::CNT_W-1:0]  div_q;
	logic [BKT_W-1:0]           clr_q;
	logic [cht_pkg::DIV_CW-1:0] div_cnt_q;
	logic                       m_tvalid_q;

	logic [cht_pkg::MODE_W-1:0]  mode_q;
	logic [cht_pkg::KEY_W-1:0]   key_q;
	logic [cht_pkg::VAL_W-1:0]   value_q;
	logic [cht_pkg::NODE_IW-1:0] node_q;
	logic [cht_pkg::DIV_BITS-1:0] kshift_q;
	logic [cht_pkg::CNT_W-1:0]   rem_q;
	logic [BKT_W-1:0]            bucket_q;
	logic [NODE_W-1:0]           cur_q;
	logic [NODE_W-1:0]           prev_q;
	logic                        has_prev_q;
	logic [NODE_W-1:0]           steps_q;
	logic                        found_q;
	logic [cht_pkg::VAL_W-1:0]   rv_q;
	logic [cht_pkg::VAL_W-1:0]   m_data_q;
	logic                        m_found_q;

	logic                        s_acc;
	logic                        out_free;
	logic [cht_pkg::CNT_W-1:0]   rem_d;
	logic [cht_pkg::CNT_W:0]     r1, r2;
	logic [cht_pkg::CNT_W:0]     dext;

	logic                 head_we;
	logic [BKT_W-1:0]     head_waddr;
	logic [HEAD_W-1:0]    head_wdata;
	logic [HEAD_W-1:0]    head_rdata;
	logic                 kv_we;
	logic [KV_W-1:0]      kv_rdata;
	logic                 link_we;
	logic [NODE_W-1:0]    link_waddr;
	logic [HEAD_W-1:0]    link_wdata;
	logic [HEAD_W-1:0]    link_rdata;
	logic [NODE_W-1:0]    node_raddr;

	logic                 node_ok;
	logic                 key_hit;
	logic                 walk_end;
	logic                 head_valid;
	logic                 link_valid;

	assign s_acc     = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == cht_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_data_q;
	assign m_tuser   = m_found_q;

	assign node_ok    = (32'(node_q) < NODES);
	assign head_valid = head_rdata[HEAD_W-1];
	assign link_valid = link_rdata[HEAD_W-1];
	assign key_hit    = (kv_rdata[cht_pkg::KEY_W-1:0] == key_q);
	assign walk_end   = !link_valid || ((32'(steps_q) + 32'd1) >= NODES);

	// two restoring remainder steps per cycle
	always_comb begin
		dext = {1'b0, div_q};
		r1 = {rem_q, kshift_q[cht_pkg::DIV_BITS-1]};
		if (r1 >= dext) begin
			r1 = r1 - dext;
		end
		r2 = {r1[cht_pkg::CNT_W-1:0], kshift_q[cht_pkg::DIV_BITS-2]};
		if (r2 >= dext) begin
			r2 = r2 - dext;
		end
		rem_d = r2[cht_pkg::CNT_W-1:0];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			cht_pkg::ST_CLEAR: begin
				if (clr_q == CLR_LAST) begin
					state_d = cht_pkg::ST_IDLE;
				end
			end
			cht_pkg::ST_IDLE: begin
				if (s_acc) begin
					state_d = cht_pkg::ST_DIV;
				end
			end
			cht_pkg::ST_DIV: begin
				if (div_cnt_q == cht_pkg::DIV_CW'(cht_pkg::DIV_STEPS - 1)) begin
					state_d = cht_pkg::ST_HEAD_RD;
				end
			end
			cht_pkg::ST_HEAD_RD: state_d = cht_pkg::ST_HEAD_CHK;
			cht_pkg::ST_HEAD_CHK: begin
				if ((mode_q == cht_pkg::MODE_LOOKUP || mode_q == cht_pkg::MODE_REMOVE)
					&& head_valid) begin
					state_d = cht_pkg::ST_NODE_CHK;
				end else begin
					state_d = cht_pkg::ST_OUT;
				end
			end
			cht_pkg::ST_NODE_CHK: begin
				if (key_hit || walk_end) begin
					state_d = cht_pkg::ST_OUT;
				end
			end
			cht_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = cht_pkg::ST_IDLE;
				end
			end
			default: state_d = cht_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		head_we    = 1'b0;
		head_waddr = bucket_q;
		head_wdata = '0;
		kv_we      = 1'b0;
		link_we    = 1'b0;
		link_waddr = NODE_W'(node_q);
		link_wdata = head_rdata;
		node_raddr = cur_q;
		case (state_q)
			cht_pkg::ST_CLEAR: begin
				head_we    = 1'b1;
				head_waddr = clr_q;
			end
			cht_pkg::ST_HEAD_CHK: begin
				node_raddr = head_rdata[NODE_W-1:0];
				if (mode_q == cht_pkg::MODE_INSERT && node_ok) begin
					head_we    = 1'b1;
					head_wdata = {1'b1, NODE_W'(node_q)};
					kv_we      = 1'b1;
					link_we    = 1'b1;
				end
			end
			cht_pkg::ST_NODE_CHK: begin
				node_raddr = link_rdata[NODE_W-1:0];
				if (key_hit && mode_q == cht_pkg::MODE_REMOVE) begin
					if (has_prev_q) begin
						link_we    = 1'b1;
						link_waddr = prev_q;
						link_wdata = link_rdata;
					end else begin
						head_we    = 1'b1;
						head_wdata = link_rdata;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= cht_pkg::ST_CLEAR;
			bucket_count_q <= cht_pkg::BUCKET_COUNT_RST;
			clr_q          <= '0;
			div_cnt_q      <= '0;
			m_tvalid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				bucket_count_q <= cfg_data;
			end
			if (state_q == cht_pkg::ST_CLEAR) begin
				clr_q <= clr_q + BKT_W'(1);
			end
			if (state_q == cht_pkg::ST_DIV) begin
				div_cnt_q <= div_cnt_q + cht_pkg::DIV_CW'(1);
			end else begin
				div_cnt_q <= '0;
			end
			if (state_q == cht_pkg::ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			cht_pkg::ST_IDLE: begin
				mode_q   <= s_tuser;
				key_q    <= s_tdata[30:0];
				value_q  <= s_tdata[62:31];
				node_q   <= s_tdata[72:63];
				kshift_q <= {1'b0, s_tdata[30:0]};
				rem_q    <= '0;
				if (bucket_count_q == '0) begin
					div_q <= 9'd1;
				end else if (bucket_count_q > DIV_MAX) begin
					div_q <= DIV_MAX;
				end else begin
					div_q <= bucket_count_q;
				end
				found_q <= 1'b0;
				rv_q    <= '0;
			end
			cht_pkg::ST_DIV: begin
				rem_q    <= rem_d;
				kshift_q <= {kshift_q[cht_pkg::DIV_BITS-3:0], 2'b00};
				bucket_q <= BKT_W'(rem_d);
			end
			cht_pkg::ST_HEAD_CHK: begin
				cur_q      <= head_rdata[NODE_W-1:0];
				has_prev_q <= 1'b0;
				steps_q    <= '0;
				if (mode_q == cht_pkg::MODE_INSERT && node_ok) begin
					found_q <= 1'b1;
				end
			end
			cht_pkg::ST_NODE_CHK: begin
				if (key_hit) begin
					found_q <= 1'b1;
					if (mode_q == cht_pkg::MODE_LOOKUP) begin
						rv_q <= kv_rdata[KV_W-1:cht_pkg::KEY_W];
					end
				end else begin
					prev_q     <= cur_q;
					has_prev_q <= 1'b1;
					cur_q      <= link_rdata[NODE_W-1:0];
					steps_q    <= steps_q + NODE_W'(1);
				end
			end
			cht_pkg::ST_OUT: begin
				if (out_free) begin
					m_data_q  <= rv_q;
					m_found_q <= found_q;
				end
			end
			default: begin
			end
		endcase
	end

	cht_ram #(
		.WIDTH(HEAD_W),
		.DEPTH(BUCKETS)
	) u_head_ram (
		.clk  (clk),
		.we   (head_we),
		.waddr(head_waddr),
		.wdata(head_wdata),
		.raddr(bucket_q),
		.rdata(head_rdata)
	);

	cht_ram #(
		.WIDTH(KV_W),
		.DEPTH(NODES)
	) u_kv_ram (
		.clk  (clk),
		.we   (kv_we),
		.waddr(NODE_W'(node_q)),
		.wdata({value_q, key_q}),
		.raddr(node_raddr),
		.rdata(kv_rdata)
	);

	cht_ram #(
		.WIDTH(HEAD_W),
		.DEPTH(NODES)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(link_waddr),
		.wdata(link_wdata),
		.raddr(node_raddr),
		.rdata(link_rdata)
	);

endmodule

>>> rtl/cht_ram.sv
// generic simple dual-port ram with registered read
module cht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
